// ----- rtl/cca_pkg.sv -----
// Shared constants and types for the circumcircle area block.
// No dependencies; circumcircle_area, cca_mul and cca_div_cell refer to it by scoped names.
package cca_pkg;

    // pi as unsigned Q2.62
    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

    // Width of one multiplier partial-product chunk
    localparam int CHUNK_W = 32;

    // Quotient bits, one per divider cell
    localparam int QUO_W = 64;

    typedef struct packed {
        logic vld;
        logic ok;
        logic sat;
    } t_flags;

endpackage

// ----- rtl/cca_if.sv -----
// Valid/ready channel interfaces for the circumcircle area block.
// Uses no package; the input width follows COORD_BITS.
interface cca_in_if #(parameter int COORD_BITS = 10);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic [COORD_BITS-1:0] bx;
    logic [COORD_BITS-1:0] by_coord;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;

    modport source (output valid, ax, ay, bx, by_coord, cx, cy, input ready);
    modport sink   (input valid, ax, ay, bx, by_coord, cx, cy, output ready);
endinterface

interface cca_out_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [63:0] area;
    logic        saturated;

    modport source (output valid, valid_res, area, saturated, input ready);
    modport sink   (input valid, valid_res, area, saturated, output ready);
endinterface

// ----- rtl/circumcircle_area.sv -----
// Circumcircle area: pi*A2*B2*C2 / (4*K^2) in unsigned Q.FRAC_BITS.
// Pipeline: differences, squares, a chain of three 3-stage multipliers,
// a quotient setup stage and a row of 64 one-bit divider cells.
// Throughput one word per cycle; the whole pipeline holds while the
// output word waits. Synchronous active-low reset empties the pipeline.
module circumcircle_area #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cca_in_if.sink       i_in,
    cca_out_if.source    o_out
);
    localparam int C    = COORD_BITS;
    localparam int D    = C + 1;
    localparam int S    = 2 * D;
    localparam int KW   = 2 * S;
    localparam int PW   = 3 * S;
    localparam int NPW  = PW + 64;
    localparam int NHW  = PW + FRAC_BITS;
    localparam int EW   = (NHW > 64 + KW) ? NHW : 64 + KW;
    localparam int QW   = cca_pkg::QUO_W;

    logic w_en;

    // difference stage
    logic                r_v1;
    logic signed [D-1:0] r_abx, r_aby, r_acx, r_acy, r_bcx, r_bcy;

    // square / cross stage
    logic                r_v2;
    logic [S-1:0]        r_s1, r_s2, r_s3;
    logic signed [S:0]   r_k;
    logic signed [S-1:0] w_sq [6];
    logic signed [S-1:0] w_c1, w_c2;
    logic signed [S:0]   w_kneg;
    logic [S-1:0]        w_kmag;

    logic [2*S-1:0]      w_p12;
    logic [KW-1:0]       w_k2a, w_k2d;
    logic [S-1:0]        w_s3d;
    logic [PW-1:0]       w_p;
    logic [NPW-1:0]      w_n;
    logic                w_vn;

    logic [NHW-1:0]      w_nh;
    logic [EW-1:0]       w_nx;
    logic                w_sat;

    // quotient setup stage
    cca_pkg::t_flags     r_f0;
    logic [KW-1:0]       r_d0;
    logic [KW-1:0]       r_r0;
    logic [QW-1:0]       r_low0;

    cca_pkg::t_flags     w_f   [QW+1];
    logic [KW-1:0]       w_d   [QW+1];
    logic [KW-1:0]       w_r   [QW+1];
    logic [QW-1:0]       w_low [QW+1];
    logic [QW-1:0]       w_q   [QW+1];

    assign w_en       = !w_f[QW].vld || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_abx <= $signed({i_in.bx[C-1], i_in.bx}) - $signed({i_in.ax[C-1], i_in.ax});
            r_aby <= $signed({i_in.by_coord[C-1], i_in.by_coord})
                     - $signed({i_in.ay[C-1], i_in.ay});
            r_acx <= $signed({i_in.cx[C-1], i_in.cx}) - $signed({i_in.ax[C-1], i_in.ax});
            r_acy <= $signed({i_in.cy[C-1], i_in.cy}) - $signed({i_in.ay[C-1], i_in.ay});
            r_bcx <= $signed({i_in.cx[C-1], i_in.cx}) - $signed({i_in.bx[C-1], i_in.bx});
            r_bcy <= $signed({i_in.cy[C-1], i_in.cy})
                     - $signed({i_in.by_coord[C-1], i_in.by_coord});
        end
    end

    assign w_sq[0] = r_abx * r_abx;
    assign w_sq[1] = r_aby * r_aby;
    assign w_sq[2] = r_acx * r_acx;
    assign w_sq[3] = r_acy * r_acy;
    assign w_sq[4] = r_bcx * r_bcx;
    assign w_sq[5] = r_bcy * r_bcy;
    assign w_c1    = r_abx * r_acy;
    assign w_c2    = r_aby * r_acx;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1 <= unsigned'(w_sq[0]) + unsigned'(w_sq[1]);
            r_s2 <= unsigned'(w_sq[2]) + unsigned'(w_sq[3]);
            r_s3 <= unsigned'(w_sq[4]) + unsigned'(w_sq[5]);
            r_k  <= (S+1)'(w_c1) - (S+1)'(w_c2);
        end
    end

    assign w_kneg = -r_k;
    assign w_kmag = r_k[S] ? w_kneg[S-1:0] : r_k[S-1:0];

    cca_mul #(.AW(S), .BW(S)) u_mul_ab (
        .i_clk (i_clk), .i_en (w_en), .i_a (r_s1), .i_b (r_s2), .o_p (w_p12)
    );

    cca_mul #(.AW(S), .BW(S)) u_mul_k (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_kmag), .i_b (w_kmag), .o_p (w_k2a)
    );

    cca_delay #(.W(S), .N(3)) u_dly_s3 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_d (r_s3), .o_q (w_s3d)
    );

    cca_mul #(.AW(2*S), .BW(S)) u_mul_abc (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_p12), .i_b (w_s3d), .o_p (w_p)
    );

    cca_mul #(.AW(PW), .BW(64)) u_mul_pi (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_p), .i_b (cca_pkg::PI_Q62), .o_p (w_n)
    );

    cca_delay #(.W(KW), .N(6)) u_dly_k2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_d (w_k2a), .o_q (w_k2d)
    );

    cca_delay #(.W(1), .N(9)) u_dly_v (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_d (r_v2), .o_q (w_vn)
    );

    // drop the 2^64 of the denominator into the dividend, then scale by 2^FRAC_BITS
    assign w_nh  = w_n[NPW-1:64-FRAC_BITS];
    assign w_nx  = EW'(w_nh);
    assign w_sat = w_nx[EW-1:64] >= (EW-64)'(w_k2d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0 <= '0;
        end else if (w_en) begin
            r_f0.vld <= w_vn;
            r_f0.ok  <= w_k2d != '0;
            r_f0.sat <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d0   <= w_k2d;
            r_r0   <= w_nx[64+KW-1:64];
            r_low0 <= w_nx[63:0];
        end
    end

    assign w_f[0]   = r_f0;
    assign w_d[0]   = r_d0;
    assign w_r[0]   = r_r0;
    assign w_low[0] = r_low0;
    assign w_q[0]   = '0;

    for (genvar g = 0; g < QW; g++) begin : g_cell
        cca_div_cell #(.KW(KW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_f     (w_f[g]),
            .i_d     (w_d[g]),
            .i_r     (w_r[g]),
            .i_low   (w_low[g]),
            .i_q     (w_q[g]),
            .o_f     (w_f[g+1]),
            .o_d     (w_d[g+1]),
            .o_r     (w_r[g+1]),
            .o_low   (w_low[g+1]),
            .o_q     (w_q[g+1])
        );
    end

    assign o_out.valid     = w_f[QW].vld;
    assign o_out.valid_res = w_f[QW].ok;
    assign o_out.saturated = w_f[QW].ok && w_f[QW].sat;
    assign o_out.area      = !w_f[QW].ok ? '0 : (w_f[QW].sat ? '1 : w_q[QW]);

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.valid_res |-> o_out.area == '0 && !o_out.saturated)
        else $error("degenerate word carries nonzero area");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.saturated |-> o_out.valid_res && (&o_out.area))
        else $error("saturated word not clamped");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_q[QW]) && $stable(w_f[QW]))
        else $error("result moved while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid && !r_v1)
        else $error("pipeline not empty after reset");
endmodule

// ----- rtl/cca_mul.sv -----
// Three-stage unsigned multiplier built from 32x32 partial products.
// Depends on cca_pkg for the chunk width.
module cca_mul #(
    parameter int AW = 22,
    parameter int BW = 22
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0] o_p
);
    localparam int CW = cca_pkg::CHUNK_W;
    localparam int NA = (AW + CW - 1) / CW;
    localparam int NB = (BW + CW - 1) / CW;
    localparam int AX = NA * CW;
    localparam int BX = NB * CW;
    localparam int RW = BX + CW;
    localparam int PW = AW + BW;

    logic [AX-1:0]     w_a;
    logic [BX-1:0]     w_b;
    logic [2*CW-1:0]   r_pp  [NA][NB];
    logic [RW-1:0]     r_row [NA];
    logic [RW-1:0]     n_row [NA];
    logic [PW-1:0]     r_acc;
    logic [AX+BX-1:0]  n_acc;

    assign w_a = AX'(i_a);
    assign w_b = BX'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= w_a[i*CW +: CW] * w_b[j*CW +: CW];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (RW'(r_pp[i][j]) << (CW * j));
            end
        end
    end

    always_comb begin
        n_acc = '0;
        for (int i = 0; i < NA; i++) begin
            n_acc = n_acc + ((AX+BX)'(r_row[i]) << (CW * i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row <= n_row;
            r_acc <= n_acc[PW-1:0];
        end
    end

    assign o_p = r_acc;
endmodule

// ----- rtl/cca_delay.sv -----
// Enabled shift register that aligns side data with the multipliers.
// No package dependency.
module cca_delay #(
    parameter int W = 1,
    parameter int N = 3
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_sh [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_sh[i] <= '0;
            end
        end else if (i_en) begin
            r_sh[0] <= i_d;
            for (int i = 1; i < N; i++) begin
                r_sh[i] <= r_sh[i-1];
            end
        end
    end

    assign o_q = r_sh[N-1];
endmodule

// ----- rtl/cca_div_cell.sv -----
// One restoring-division cell: produces one quotient bit per word.
// Depends on cca_pkg for the flag struct and quotient width.
module cca_div_cell #(
    parameter int KW = 44
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  cca_pkg::t_flags                i_f,
    input  logic [KW-1:0]                  i_d,
    input  logic [KW-1:0]                  i_r,
    input  logic [cca_pkg::QUO_W-1:0]      i_low,
    input  logic [cca_pkg::QUO_W-1:0]      i_q,
    output cca_pkg::t_flags                o_f,
    output logic [KW-1:0]                  o_d,
    output logic [KW-1:0]                  o_r,
    output logic [cca_pkg::QUO_W-1:0]      o_low,
    output logic [cca_pkg::QUO_W-1:0]      o_q
);
    localparam int QW = cca_pkg::QUO_W;

    logic [KW:0]   w_t;
    logic [KW:0]   w_diff;
    logic          w_ge;
    logic [KW-1:0] n_r;

    // shift the next dividend bit into the partial remainder
    assign w_t    = {i_r, i_low[QW-1]};
    assign w_diff = w_t - {1'b0, i_d};
    assign w_ge   = w_t >= {1'b0, i_d};
    assign n_r    = w_ge ? w_diff[KW-1:0] : w_t[KW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_f <= '0;
        end else if (i_en) begin
            o_f <= i_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_d   <= i_d;
            o_r   <= n_r;
            o_low <= {i_low[QW-2:0], 1'b0};
            o_q   <= {i_q[QW-2:0], w_ge};
        end
    end
endmodule
